### src/cba_pkg.sv
// Shared types and constants for the contiguous bank allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none
package cba_pkg;

  // Per-bank marks kept in the bank memory.
  typedef struct packed {
    logic free;
    logic head;
    logic link;
  } mark_t;

  localparam mark_t MARK_RESET = '{free: 1'b1, head: 1'b0, link: 1'b0};

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_MARK  = 4'b1000
  } state_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic [CFG_DW-1:0] HEAP_BASE_RESET = 32'd46848;

endpackage
`default_nettype wire

### src/cba_cfg.sv
// APB-style register port holding the heap base address.
// Depends on cba_pkg for the register map and widths.
`default_nettype none
module cba_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cba_pkg::CFG_AW-1:0] paddr,
  input  wire logic [cba_pkg::CFG_DW-1:0] pwdata,
  output logic      [cba_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output logic      [31:0]                heap_base
);
  import cba_pkg::*;

  logic [CFG_DW-1:0] base_r;
  logic [CFG_DW-1:0] base_nxt;
  logic              reg_idx;
  logic              wr_hit;

  assign reg_idx = paddr[CFG_AW-1];
  assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_HEAP_BASE);

  always_comb begin
    base_nxt = base_r;
    if (wr_hit) begin
      base_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= HEAP_BASE_RESET;
    end else begin
      base_r <= base_nxt;
    end
  end

  assign prdata    = (reg_idx == REG_HEAP_BASE) ? base_r : '0;
  assign pready    = 1'b1;
  assign heap_base = base_r;

endmodule
`default_nettype wire

### src/cba_bank_mem.sv
// Bank mark memory: one write port and one read port with registered read data.
// Depends on cba_pkg for the mark entry type.
`default_nettype none
module cba_bank_mem #(
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_idx,
  input  wire cba_pkg::mark_t           wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_idx,
  output cba_pkg::mark_t                rd_data
);
  import cba_pkg::*;

  mark_t mem [DEPTH];
  mark_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### src/cba_seq.sv
// Sequencer and shared scan datapath: clearing pass, first-fit search,
// run marking and run release, one bank per cycle. Depends on cba_pkg.
`default_nettype none
module cba_seq #(
  parameter int BANK_COUNT = 128,
  parameter int BANK_BYTES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_req_type,
  input  wire logic [31:0]                   in_request_size,
  input  wire logic [31:0]                   in_free_address,
  input  wire logic [31:0]                   heap_base,
  output logic                               mem_wr_en,
  output logic      [$clog2(BANK_COUNT)-1:0] mem_wr_idx,
  output cba_pkg::mark_t                     mem_wr_data,
  output logic      [$clog2(BANK_COUNT)-1:0] mem_rd_idx,
  input  wire cba_pkg::mark_t                mem_rd_data,
  output logic                               out_valid,
  output logic      [31:0]                   out_start_address,
  output logic                               out_illegal_free
);
  import cba_pkg::*;

  localparam int IDX_W      = $clog2(BANK_COUNT);
  localparam int CNT_W      = $clog2(BANK_COUNT + 1);
  localparam int HEAP_BYTES = BANK_COUNT * BANK_BYTES;
  localparam int RUN_W      = $clog2(HEAP_BYTES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BANK_COUNT - 1);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              eval_vld_r, eval_vld_nxt;
  logic [IDX_W-1:0]  eval_idx_r, eval_idx_nxt;
  logic [31:0]       eval_addr_r, eval_addr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RUN_W-1:0]  bytes_r, bytes_nxt;
  logic [31:0]       run_addr_r, run_addr_nxt;
  logic              releasing_r, releasing_nxt;
  logic              req_type_r, req_type_nxt;
  logic [31:0]       req_size_r, req_size_nxt;
  logic [31:0]       free_addr_r, free_addr_nxt;
  logic [IDX_W-1:0]  mark_idx_r, mark_idx_nxt;
  logic [CNT_W-1:0]  mark_left_r, mark_left_nxt;
  logic              mark_first_r, mark_first_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_addr_r, out_addr_nxt;
  logic              out_ill_r, out_ill_nxt;

  logic              eval_last;
  logic              scan_last;
  logic              eval_match;
  logic [CNT_W-1:0]  cnt_inc;
  logic [RUN_W-1:0]  bytes_inc;
  logic              fit;

  assign eval_last  = (eval_idx_r == LAST_IDX);
  assign scan_last  = (scan_idx_r == LAST_IDX);
  assign eval_match = (eval_addr_r == free_addr_r) && mem_rd_data.head && !mem_rd_data.free;
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign bytes_inc  = bytes_r + RUN_W'(BANK_BYTES);
  assign fit        = mem_rd_data.free && (32'(bytes_inc) >= req_size_r);

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    eval_vld_nxt   = eval_vld_r;
    eval_idx_nxt   = eval_idx_r;
    eval_addr_nxt  = eval_addr_r;
    cnt_nxt        = cnt_r;
    bytes_nxt      = bytes_r;
    run_addr_nxt   = run_addr_r;
    releasing_nxt  = releasing_r;
    req_type_nxt   = req_type_r;
    req_size_nxt   = req_size_r;
    free_addr_nxt  = free_addr_r;
    mark_idx_nxt   = mark_idx_r;
    mark_left_nxt  = mark_left_r;
    mark_first_nxt = mark_first_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_ill_nxt    = out_ill_r;
    mem_wr_en      = 1'b0;
    mem_wr_idx     = eval_idx_r;
    mem_wr_data    = MARK_RESET;
    mem_rd_idx     = scan_idx_r;

    case (state_r)
      ST_CLEAR: begin
        mem_wr_en  = 1'b1;
        mem_wr_idx = scan_idx_r;
        if (scan_last) begin
          scan_idx_nxt = '0;
          state_nxt    = ST_IDLE;
        end else begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_type_nxt  = in_req_type;
          req_size_nxt  = in_request_size;
          free_addr_nxt = in_free_address;
          scan_idx_nxt  = '0;
          eval_vld_nxt  = 1'b0;
          eval_idx_nxt  = '0;
          eval_addr_nxt = heap_base;
          cnt_nxt       = '0;
          bytes_nxt     = '0;
          releasing_nxt = 1'b0;
          if ((in_req_type == REQ_ALLOC) && (in_request_size == '0)) begin
            out_valid_nxt = 1'b1;
            out_addr_nxt  = '0;
            out_ill_nxt   = 1'b0;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        eval_vld_nxt = 1'b1;
        if (!scan_last) begin
          scan_idx_nxt = scan_idx_r + IDX_W'(1);
        end
        if (eval_vld_r) begin
          eval_idx_nxt  = eval_idx_r + IDX_W'(1);
          eval_addr_nxt = eval_addr_r + 32'(BANK_BYTES);
          if (req_type_r == REQ_ALLOC) begin
            if (mem_rd_data.free) begin
              cnt_nxt   = cnt_inc;
              bytes_nxt = bytes_inc;
              if (cnt_r == '0) begin
                run_addr_nxt = eval_addr_r;
              end
            end else begin
              cnt_nxt   = '0;
              bytes_nxt = '0;
            end
            if (fit) begin
              state_nxt      = ST_MARK;
              mark_idx_nxt   = eval_idx_r;
              mark_left_nxt  = cnt_inc;
              mark_first_nxt = 1'b1;
              out_addr_nxt   = (cnt_r == '0) ? eval_addr_r : run_addr_r;
              out_ill_nxt    = 1'b0;
            end else if (eval_last) begin
              state_nxt     = ST_IDLE;
              out_valid_nxt = 1'b1;
              out_addr_nxt  = '0;
              out_ill_nxt   = 1'b0;
            end
          end else begin
            if (releasing_r || eval_match) begin
              mem_wr_en  = 1'b1;
              mem_wr_idx = eval_idx_r;
              if (!mem_rd_data.link || eval_last) begin
                state_nxt     = ST_IDLE;
                releasing_nxt = 1'b0;
                out_valid_nxt = 1'b1;
                out_addr_nxt  = '0;
                out_ill_nxt   = 1'b0;
              end else begin
                releasing_nxt = 1'b1;
              end
            end else if (eval_last) begin
              state_nxt     = ST_IDLE;
              out_valid_nxt = 1'b1;
              out_addr_nxt  = '0;
              out_ill_nxt   = 1'b1;
            end
          end
        end
      end
      ST_MARK: begin
        mem_wr_en        = 1'b1;
        mem_wr_idx       = mark_idx_r;
        mem_wr_data.free = 1'b0;
        mem_wr_data.head = (mark_left_r == CNT_W'(1));
        mem_wr_data.link = !mark_first_r;
        mark_first_nxt   = 1'b0;
        if (mark_left_r == CNT_W'(1)) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          mark_idx_nxt  = mark_idx_r - IDX_W'(1);
          mark_left_nxt = mark_left_r - CNT_W'(1);
        end
      end
      default: begin
        state_nxt    = ST_CLEAR;
        scan_idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      scan_idx_r  <= '0;
      eval_vld_r  <= 1'b0;
      releasing_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      eval_vld_r  <= eval_vld_nxt;
      releasing_r <= releasing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r   <= eval_idx_nxt;
    eval_addr_r  <= eval_addr_nxt;
    cnt_r        <= cnt_nxt;
    bytes_r      <= bytes_nxt;
    run_addr_r   <= run_addr_nxt;
    req_type_r   <= req_type_nxt;
    req_size_r   <= req_size_nxt;
    free_addr_r  <= free_addr_nxt;
    mark_idx_r   <= mark_idx_nxt;
    mark_left_r  <= mark_left_nxt;
    mark_first_r <= mark_first_nxt;
    out_addr_r   <= out_addr_nxt;
    out_ill_r    <= out_ill_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_start_address = out_addr_r;
  assign out_illegal_free  = out_ill_r;

  a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_ill_r && (out_addr_r != '0)))
    else $error("allocate address and illegal free raised together");

  a_mark_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> (mark_left_r != '0))
    else $error("run marking entered with an empty run");

  a_release_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    releasing_r |-> ((state_r == ST_SCAN) && (req_type_r == REQ_FREE)))
    else $error("run release active outside a free scan");

  a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ((state_r == ST_SCAN) || out_valid_r))
    else $error("accepted request neither scanned nor answered");

endmodule
`default_nettype wire

### src/contiguous_bank_allocator.sv
// A zero-size allocate answers in the cycle after start. Otherwise the scan reads
// one bank per cycle from the bank memory; the result is registered after the deciding
// bank is evaluated, and a successful allocate first marks each bank of the run.
// One request at a time: start is taken only while busy is low.
// Reset: a clearing pass marks every bank free; busy is high meanwhile.
// Each result beat is shown for one cycle on out_valid; the receiver cannot stall.
`default_nettype none
module contiguous_bank_allocator #(
  parameter int BANK_COUNT = 128,
  parameter int BANK_BYTES = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_req_type,
  input  wire logic [31:0]                in_request_size,
  input  wire logic [31:0]                in_free_address,
  output logic                            out_valid,
  output logic      [31:0]                out_start_address,
  output logic                            out_illegal_free,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cba_pkg::CFG_AW-1:0] paddr,
  input  wire logic [cba_pkg::CFG_DW-1:0] pwdata,
  output logic      [cba_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);
  import cba_pkg::*;

  localparam int IDX_W = $clog2(BANK_COUNT);

  logic [31:0]      heap_base;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_idx;
  mark_t            mem_wr_data;
  logic [IDX_W-1:0] mem_rd_idx;
  mark_t            mem_rd_data;

  cba_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .heap_base (heap_base)
  );

  cba_bank_mem #(
    .DEPTH (BANK_COUNT)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_idx  (mem_wr_idx),
    .wr_data (mem_wr_data),
    .rd_idx  (mem_rd_idx),
    .rd_data (mem_rd_data)
  );

  cba_seq #(
    .BANK_COUNT (BANK_COUNT),
    .BANK_BYTES (BANK_BYTES)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_request_size   (in_request_size),
    .in_free_address   (in_free_address),
    .heap_base         (heap_base),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_idx        (mem_wr_idx),
    .mem_wr_data       (mem_wr_data),
    .mem_rd_idx        (mem_rd_idx),
    .mem_rd_data       (mem_rd_data),
    .out_valid         (out_valid),
    .out_start_address (out_start_address),
    .out_illegal_free  (out_illegal_free)
  );

endmodule
`default_nettype wire

### dv/cba_heap_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the contiguous bank allocator: a first-fit heap predictor and
// the queue of answers it expects. Depends on cba_pkg.
package cba_tb_pkg;
  import cba_pkg::*;

  localparam int NUM_BANKS = 128;
  localparam int BANK_SZ = 64;

  typedef struct packed {
    logic [31:0] start_address;
    logic        illegal_free;
  } heap_answer_t;

  class heap_scoreboard;
    logic [31:0]  heap_base;
    bit           is_free[NUM_BANKS];
    bit           is_head[NUM_BANKS];
    bit           links[NUM_BANKS];
    heap_answer_t answers_q[$];
    int           errors;
    int           n_alloc_ok, n_alloc_fail, n_free_ok, n_free_bad, n_base_writes;

    function new();
      heap_base = HEAP_BASE_RESET;
      for (int i = 0; i < NUM_BANKS; i++) begin
        is_free[i] = 1'b1;
        is_head[i] = 1'b0;
        links[i] = 1'b0;
      end
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      if (idx == REG_HEAP_BASE) begin
        heap_base = value;
        n_base_writes++;
      end
    endfunction

    function logic [31:0] bank_address(int i);
      logic [31:0] offset;
      offset = i * BANK_SZ;
      return heap_base + offset;
    endfunction

    function int free_banks();
      int n;
      n = 0;
      foreach (is_free[i]) n += is_free[i];
      return n;
    endfunction

    function bit pick_head(output int idx);
      int s;
      s = $urandom_range(0, NUM_BANKS - 1);
      for (int k = 0; k < NUM_BANKS; k++) begin
        idx = (s + k) % NUM_BANKS;
        if (is_head[idx] && !is_free[idx]) return 1'b1;
      end
      return 1'b0;
    endfunction

    // First fit, lowest bank first; returns 1 and the run's address on success.
    function bit allocate(logic [31:0] size, output logic [31:0] addr);
      int need, run, first;
      addr = '0;
      if (size == 0 || size > NUM_BANKS * BANK_SZ) return 1'b0;
      need = (size + BANK_SZ - 1) / BANK_SZ;
      run = 0;
      for (int i = 0; i < NUM_BANKS; i++) begin
        run = is_free[i] ? run + 1 : 0;
        if (run == need) begin
          first = i + 1 - need;
          for (int j = first; j <= i; j++) begin
            is_free[j] = 1'b0;
            is_head[j] = (j == first);
            links[j] = (j < i);
          end
          addr = bank_address(first);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function bit release_run(logic [31:0] addr);
      bit more;
      int j;
      for (int i = 0; i < NUM_BANKS; i++) begin
        if (bank_address(i) == addr && is_head[i] && !is_free[i]) begin
          j = i;
          do begin
            more = links[j];
            is_free[j] = 1'b1;
            is_head[j] = 1'b0;
            links[j] = 1'b0;
            j++;
          end while (more && j < NUM_BANKS);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic req, logic [31:0] size, logic [31:0] addr);
      heap_answer_t ans;
      ans = '0;
      if (req == REQ_ALLOC) begin
        if (allocate(size, ans.start_address)) n_alloc_ok++;
        else n_alloc_fail++;
      end else begin
        ans.illegal_free = !release_run(addr);
        if (ans.illegal_free) n_free_bad++;
        else n_free_ok++;
      end
      answers_q.push_back(ans);
    endfunction

    function int pending();
      return answers_q.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 20) $display("%0t ERROR: %s", $time, what);
    endtask

    task check_result(logic [31:0] start_address, logic illegal_free);
      heap_answer_t ans;
      if (answers_q.size() == 0) begin
        report($sformatf("result beat with no request pending (start_address %h)",
                         start_address));
      end else begin
        ans = answers_q.pop_front();
        if (start_address !== ans.start_address)
          report($sformatf("start_address %h, expected %h", start_address,
                           ans.start_address));
        if (illegal_free !== ans.illegal_free)
          report($sformatf("illegal_free %b, expected %b", illegal_free,
                           ans.illegal_free));
      end
    endtask
  endclass

endpackage

### dv/tb_contiguous_bank_allocator.sv
`timescale 1ns / 100ps
// Top-level testbench for contiguous_bank_allocator: directed and random
// allocate/free traffic checked against the heap scoreboard in cba_tb_pkg.
module tb_contiguous_bank_allocator;
  import cba_pkg::*;
  import cba_tb_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ITEMS_PER_PHASE = 288;
  localparam int NUM_PHASES = 6;
  localparam int REG_UNUSED = 1;
  localparam logic [CFG_AW-1:0] ADDR_HEAP_BASE = CFG_AW'(4 * REG_HEAP_BASE);
  localparam logic [CFG_AW-1:0] ADDR_UNUSED = CFG_AW'(4 * REG_UNUSED);

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_req_type;
  logic [31:0]       in_request_size;
  logic [31:0]       in_free_address;
  logic              out_valid;
  logic [31:0]       out_start_address;
  logic              out_illegal_free;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  heap_scoreboard sb;
  int             cycle_count;

  contiguous_bank_allocator #(
    .BANK_COUNT(NUM_BANKS),
    .BANK_BYTES(BANK_SZ)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_request_size(in_request_size),
    .in_free_address(in_free_address),
    .out_valid(out_valid),
    .out_start_address(out_start_address),
    .out_illegal_free(out_illegal_free),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d answers pending.", cycle_count,
               sb.pending());
      $display("tb_contiguous_bank_allocator failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_start_address, out_illegal_free);
  end

  task automatic issue(logic req, logic [31:0] size, logic [31:0] addr, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_request_size <= size;
    in_free_address <= addr;
    do @(posedge clk); while (busy);
    sb.note_request(req, size, addr);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(addr >> 2, data);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check_base();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_HEAP_BASE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== sb.heap_base)
      sb.report($sformatf("heap base reads %h, expected %h", prdata, sb.heap_base));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_heap_base(logic [31:0] base);
    cfg_write(ADDR_HEAP_BASE, base);
    cfg_check_base();
  endtask

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'd0;
    if (r < 6) return $urandom;
    if (r < 9) return $urandom_range(NUM_BANKS * BANK_SZ + 1, 4 * NUM_BANKS * BANK_SZ);
    if (r < 14) return $urandom_range(1, NUM_BANKS * BANK_SZ);
    if (r < 22) return $urandom_range(1, 16) * BANK_SZ;
    return $urandom_range(1, 16 * BANK_SZ);
  endfunction

  task automatic random_request(int gap);
    int          r, idx, free_pct;
    bit          have_head;
    logic [31:0] addr;
    have_head = sb.pick_head(idx);
    if (!have_head) free_pct = 10;
    else if (sb.free_banks() < 16) free_pct = 65;
    else free_pct = 40;
    if ($urandom_range(0, 99) >= free_pct) begin
      issue(REQ_ALLOC, rand_size(), $urandom, gap);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70 && have_head) addr = sb.bank_address(idx);
      else if (r < 80) addr = sb.bank_address($urandom_range(0, NUM_BANKS - 1));
      else if (r < 90) addr = sb.bank_address(idx) + $urandom_range(1, BANK_SZ - 1);
      else addr = $urandom;
      issue(REQ_FREE, $urandom, addr, gap);
    end
  endtask

  function automatic logic [31:0] phase_base(int ph);
    case (ph)
      1: return 32'hFFFF_FFC0;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'hFFFF_F000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] b;
    sb = new();
    cycle_count <= 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_req_type <= REQ_ALLOC;
    in_request_size <= '0;
    in_free_address <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    drain_results();
    cfg_check_base();

    // Size edge cases, first-fit hole reuse, bad frees and a full heap.
    b = sb.heap_base;
    issue(REQ_ALLOC, 32'd0, $urandom, 0);
    issue(REQ_ALLOC, NUM_BANKS * BANK_SZ + 1, $urandom, 0);
    issue(REQ_ALLOC, 32'hFFFF_FFFF, $urandom, 0);
    issue(REQ_ALLOC, 32'd1, $urandom, 0);
    issue(REQ_ALLOC, BANK_SZ, $urandom, 0);
    issue(REQ_ALLOC, BANK_SZ + 1, $urandom, 0);
    issue(REQ_FREE, $urandom, b + BANK_SZ, 0);
    issue(REQ_FREE, $urandom, b + 3 * BANK_SZ, 0);
    issue(REQ_FREE, $urandom, b + BANK_SZ, 0);
    issue(REQ_ALLOC, BANK_SZ, $urandom, 0);
    issue(REQ_ALLOC, NUM_BANKS * BANK_SZ, $urandom, 0);
    issue(REQ_FREE, $urandom, b, 0);
    issue(REQ_FREE, $urandom, b + 2 * BANK_SZ, 0);
    issue(REQ_FREE, $urandom, b + BANK_SZ, 0);
    issue(REQ_ALLOC, NUM_BANKS * BANK_SZ, 32'h0, 0);
    issue(REQ_ALLOC, 32'd1, $urandom, 0);
    issue(REQ_FREE, 32'h0, b, 0);
    issue(REQ_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

    // Bank one wraps to address zero: it is allocated but answers zero.
    drain_results();
    set_heap_base(32'hFFFF_FFC0);
    issue(REQ_ALLOC, BANK_SZ, $urandom, 0);
    issue(REQ_ALLOC, BANK_SZ, $urandom, 0);
    issue(REQ_FREE, $urandom, 32'h0, 0);
    issue(REQ_FREE, $urandom, 32'hFFFF_FFC0, 0);

    // A write to an unmapped register must leave the heap base alone.
    drain_results();
    cfg_write(ADDR_UNUSED, $urandom);
    cfg_check_base();
    set_heap_base(HEAP_BASE_RESET);
    issue(REQ_ALLOC, (NUM_BANKS - 1) * BANK_SZ, 32'hFFFF_FFFF, 0);
    issue(REQ_FREE, 32'hFFFF_FFFF, HEAP_BASE_RESET, 0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        set_heap_base(phase_base(ph));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) == 0) drain_results();
        random_request((ph % 3 == 1) ? 0 : rand_gap());
      end
    end

    drain_results();
    repeat (2 * NUM_BANKS + 8) @(posedge clk);
    $display("Covered %0d allocations (%0d failed) and %0d frees (%0d illegal)",
             sb.n_alloc_ok + sb.n_alloc_fail, sb.n_alloc_fail,
             sb.n_free_ok + sb.n_free_bad, sb.n_free_bad);
    $display("across %0d heap base settings, with %0d mismatches.", sb.n_base_writes + 1,
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_contiguous_bank_allocator passed");
    end else begin
      $display("tb_contiguous_bank_allocator failed");
    end
    $finish;
  end

endmodule
